>>> hw/rtl/ptid_pkg.sv
// Shared types and constants for the period table index decomposition block.
package ptid_pkg;

   localparam int unsigned DATA_W = 48;
   localparam int unsigned SLOT_W = 5;
   localparam int unsigned LCNT_W = 6;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CNT_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERT_MARGIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_MODE = 2'd2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic MODE_IDENTITY = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LEVEL,
      ST_DIV,
      ST_MUL,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> hw/rtl/ptid_if.sv
// Request and response channel interfaces.
interface ptid_req_if;
   import ptid_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SLOT_W-1:0]   level_slot;
   logic [DATA_W-1:0]   level_period;
   logic [DATA_W-1:0]   level_elements;
   logic [DATA_W-1:0]   iteration;
   modport source (output valid, req_type, level_slot, level_period, level_elements,
                   iteration, input ready);
   modport sink (input valid, req_type, level_slot, level_period, level_elements,
                 iteration, output ready);
endinterface

interface ptid_rsp_if;
   import ptid_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   table_index;
   logic                index_valid;
   modport source (output valid, table_index, index_valid, input ready);
   modport sink (input valid, table_index, index_valid, output ready);
endinterface

>>> hw/rtl/ptid_ram.sv
// Generic single write port RAM with registered read.
module ptid_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/ptid_div.sv
// Serial restoring divider, one quotient bit per cycle.
module ptid_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ptid_pkg::DATA_W-1:0] dividend,
   input  logic [ptid_pkg::DATA_W-1:0] divisor,
   output ptid_pkg::div_status_type    status,
   output logic [ptid_pkg::DATA_W-1:0] quotient,
   output logic [ptid_pkg::DATA_W-1:0] remainder
);
   import ptid_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DATA_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DATA_W'(trial - {1'b0, dvs_ff}) : trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
endmodule

>>> hw/rtl/period_table_index_decompose.sv
// Load writes a table entry. Query in identity mode: response in the cycle after the request.
// Query in decomposition mode: each level is read and checked; a skipped level returns to the read,
// a used level goes through the serial divider, the shift-add multiply and an accumulate step,
// and a finish step forms the response. One request in flight; ready returns once the
// response has been taken. Synchronous active-high reset clears control and config only.
module period_table_index_decompose #(
   parameter int unsigned MAX_LEVELS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   ptid_req_if.sink                       req_chan,
   ptid_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [ptid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptid_pkg::DATA_W-1:0]    csr_wdata
);
   import ptid_pkg::*;

   localparam int unsigned AW = MAX_LEVELS > 1 ? $clog2(MAX_LEVELS) : 1;
   localparam int unsigned LW = $clog2(MAX_LEVELS + 1);
   localparam int unsigned NW = LCNT_W + 1;

   state_type state_ff, state_in;

   logic [LCNT_W-1:0] lcount_ff;
   logic [DATA_W-1:0] margin_ff;
   logic              mode_ff;
   logic [DATA_W-1:0] p0_ff;

   logic [LW-1:0]     lvl_ff, lvl_in;
   logic [LW-1:0]     nlvl_ff, nlvl_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] x_ff, x_in;
   logic [DATA_W-1:0] prev_p_ff, prev_p_in;
   logic [DATA_W-1:0] e_ff, e_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  mcnt_ff, mcnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_index_ff, rsp_index_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic                  req_fire;
   logic                  load_ok;
   logic [2*DATA_W-1:0]   rd_data;
   logic [DATA_W-1:0]     rd_p;
   logic [DATA_W-1:0]     rd_e;
   logic [AW-1:0]         rd_addr;
   logic                  div_start;
   div_status_type        div_st;
   logic [DATA_W-1:0]     div_q;
   logic [DATA_W-1:0]     div_r;
   logic [DATA_W+1:0]     lhs;
   logic [DATA_W+1:0]     rhs;
   logic [DATA_W+1:0]     msum;
   logic [DATA_W:0]       xsum;
   logic [NW-1:0]         lcount_ext;

   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign load_ok  = req_fire && (req_chan.req_type == REQ_LOAD)
                     && ({2'b00, req_chan.level_slot} < 7'(MAX_LEVELS));

   ptid_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAX_LEVELS)) u_table (
      .clock  (clock),
      .wr_en  (load_ok),
      .wr_addr(AW'(req_chan.level_slot)),
      .wr_data({req_chan.level_elements, req_chan.level_period}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_p    = rd_data[DATA_W-1:0];
   assign rd_e    = rd_data[2*DATA_W-1:DATA_W];
   assign rd_addr = AW'(lvl_ff - 1'b1);

   ptid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (r_ff),
      .divisor  (rd_p),
      .status   (div_st),
      .quotient (div_q),
      .remainder(div_r)
   );

   // level too short against the level above
   assign lhs  = {2'b00, r_ff} + {2'b00, p0_ff} + 1'b1;
   assign rhs  = {2'b00, prev_p_ff} + {2'b00, margin_ff};
   assign msum = {1'b0, acc_ff, 1'b0} + {2'b00, (q_ff[DATA_W-1] ? e_ff : '0)};
   assign xsum = {1'b0, x_ff} + {1'b0, acc_ff};
   assign lcount_ext = {1'b0, lcount_ff};
   assign div_start = (state_ff == ST_LEVEL) && (rd_p != '0) && (r_ff >= rd_p)
                      && !((lvl_ff != nlvl_ff) && (lhs > rhs));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.req_type == REQ_QUERY && mode_ff != MODE_IDENTITY
                && req_chan.iteration != '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = (lvl_ff == '0) ? ST_FINISH : ST_LEVEL;
         ST_LEVEL: begin
            if (rd_p == '0 || r_ff < rd_p) begin
               state_in = ST_READ;
            end else if (div_start) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV:    state_in = div_st.done ? ST_MUL : ST_DIV;
         ST_MUL:    state_in = (mcnt_ff == '0) ? ST_ACCUM : ST_MUL;
         ST_ACCUM:  state_in = (ovf_ff || xsum[DATA_W]) ? ST_IDLE : ST_READ;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      lvl_in       = lvl_ff;
      nlvl_in      = nlvl_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      prev_p_in    = prev_p_ff;
      e_in         = e_ff;
      q_in         = q_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      mcnt_in      = mcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in = rsp_index_ff;
      rsp_ok_in    = rsp_ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.req_type == REQ_QUERY) begin
               if (mode_ff == MODE_IDENTITY) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = req_chan.iteration;
                  rsp_ok_in    = 1'b1;
               end else if (req_chan.iteration == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_ok_in    = 1'b0;
               end
               nlvl_in = (lcount_ext > NW'(MAX_LEVELS)) ? LW'(MAX_LEVELS)
                                                        : LW'(lcount_ff);
               lvl_in  = nlvl_in;
               r_in    = req_chan.iteration;
               x_in    = '0;
            end
         end
         ST_READ: begin
         end
         ST_LEVEL: begin
            prev_p_in = rd_p;
            e_in      = rd_e;
            if (rd_p == '0 || r_ff < rd_p) begin
               lvl_in = lvl_ff - 1'b1;
            end else if (!div_start) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_ok_in    = 1'b0;
            end
         end
         ST_DIV: begin
            q_in    = div_q;
            acc_in  = '0;
            ovf_in  = 1'b0;
            mcnt_in = CNT_W'(DATA_W - 1);
         end
         ST_MUL: begin
            q_in    = {q_ff[DATA_W-2:0], 1'b0};
            acc_in  = msum[DATA_W-1:0];
            ovf_in  = ovf_ff || (msum[DATA_W+1:DATA_W] != 2'b00);
            mcnt_in = mcnt_ff - 1'b1;
         end
         ST_ACCUM: begin
            if (ovf_ff || xsum[DATA_W]) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_ok_in    = 1'b0;
            end else begin
               x_in   = xsum[DATA_W-1:0];
               r_in   = div_r;
               lvl_in = lvl_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = (r_ff == DATA_W'(1));
            rsp_index_in = (r_ff == DATA_W'(1)) ? x_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lcount_ff    <= '0;
         margin_ff    <= '0;
         mode_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LEVEL_COUNT: lcount_ff <= csr_wdata[LCNT_W-1:0];
               CSR_PERT_MARGIN: margin_ff <= csr_wdata;
               CSR_INDEX_MODE:  mode_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      if (load_ok && req_chan.level_slot == '0) begin
         p0_ff <= req_chan.level_period;
      end
      lvl_ff       <= lvl_in;
      nlvl_ff      <= nlvl_in;
      r_ff         <= r_in;
      x_ff         <= x_in;
      prev_p_ff    <= prev_p_in;
      e_ff         <= e_in;
      q_ff         <= q_in;
      acc_ff       <= acc_in;
      ovf_ff       <= ovf_in;
      mcnt_ff      <= mcnt_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.table_index = rsp_index_ff;
   assign rsp_chan.index_valid = rsp_ok_ff;
endmodule
